/* rtl/core/hrf_pkg.sv */
// Package of shared types, constants and character helpers for the HTTP response framer.
package hrf_pkg;

   localparam int unsigned LINE_MAX_DEFAULT = 1024;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [15:0] SAT16 = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_STATUS   = 3'd0,
      PH_HEADER   = 3'd1,
      PH_CONTINUE = 3'd2,
      PH_DATA     = 3'd3,
      PH_CHUNKED  = 3'd4,
      PH_FOOTER   = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   typedef enum logic [4:0] {
      K_S_PFX, K_S_MAJ_WS, K_S_MAJ_DIG, K_S_MIN_WS, K_S_MIN_DIG, K_S_ST_WS,
      K_S_ST_DIG, K_S_OK, K_S_FAIL,
      K_H_START, K_H_CL_PFX, K_H_TE_PFX, K_H_CL_WS, K_H_CL_SIGN, K_H_CL_DIG,
      K_H_CL_END, K_H_TE_WS, K_H_TE_VAL, K_H_TE_OK, K_H_NONE,
      K_X_WS, K_X_SIGN, K_X_ZERO, K_X_X, K_X_DIG, K_X_END, K_X_BAD,
      K_IDLE
   } kind_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_STATUS  = 3'd1,
      EV_HEADER  = 3'd2,
      EV_BODY    = 3'd3,
      EV_FOOTER  = 3'd4,
      EV_DONE    = 3'd5,
      EV_BADCHNK = 3'd6,
      EV_IGNORED = 3'd7
   } event_type;

   typedef struct packed {
      logic [2:0]  event_code;
      logic [7:0]  body_byte;
      logic [15:0] status_code;
      logic [15:0] version_major;
      logic [15:0] version_minor;
      logic        body_expected;
      logic        chunked_mode;
      logic        reply_done;
   } result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   // Hex digit value in the low nibble, bit 4 set when the byte is a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [7:0] c;
      c = to_lower(b);
      if (is_dig(b)) return {1'b1, b[3:0]};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic logic [7:0] http_char(input logic [4:0] i);
      case (i)
         5'd0: return 8'h48;
         5'd1: return 8'h54;
         5'd2: return 8'h54;
         5'd3: return 8'h50;
         5'd4: return 8'h2F;
         default: return 8'h00;
      endcase
   endfunction

   // "content-length:"
   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: return 8'h63; 5'd1: return 8'h6F; 5'd2: return 8'h6E; 5'd3: return 8'h74;
         5'd4: return 8'h65; 5'd5: return 8'h6E; 5'd6: return 8'h74; 5'd7: return 8'h2D;
         5'd8: return 8'h6C; 5'd9: return 8'h65; 5'd10: return 8'h6E; 5'd11: return 8'h67;
         5'd12: return 8'h74; 5'd13: return 8'h68; 5'd14: return 8'h3A;
         default: return 8'h00;
      endcase
   endfunction

   // "transfer-encoding:"
   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: return 8'h74; 5'd1: return 8'h72; 5'd2: return 8'h61; 5'd3: return 8'h6E;
         5'd4: return 8'h73; 5'd5: return 8'h66; 5'd6: return 8'h65; 5'd7: return 8'h72;
         5'd8: return 8'h2D; 5'd9: return 8'h65; 5'd10: return 8'h6E; 5'd11: return 8'h63;
         5'd12: return 8'h6F; 5'd13: return 8'h64; 5'd14: return 8'h69; 5'd15: return 8'h6E;
         5'd16: return 8'h67; 5'd17: return 8'h3A;
         default: return 8'h00;
      endcase
   endfunction

   // "chunked"
   function automatic logic [7:0] ch_char(input logic [4:0] i);
      case (i)
         5'd0: return 8'h63; 5'd1: return 8'h68; 5'd2: return 8'h75; 5'd3: return 8'h6E;
         5'd4: return 8'h6B; 5'd5: return 8'h65; 5'd6: return 8'h64;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [15:0] sat16_mac(input logic [15:0] v, input logic [3:0] d);
      logic [20:0] t;
      t = {5'd0, v} * 21'd10 + {17'd0, d};
      return (t > 21'd65535) ? SAT16 : t[15:0];
   endfunction

   // Accumulate one digit; base 16 uses a shift, base 10 a shift-and-add.
   function automatic logic [31:0] acc_mac(input logic [31:0] a, input logic hex,
                                           input logic [3:0] d);
      logic [35:0] t;
      if (hex) t = {a, 4'd0} + {32'd0, d};
      else t = {1'b0, a, 3'd0} + {3'd0, a, 1'b0} + {32'd0, d};
      return (t > {4'd0, SAT32}) ? SAT32 : t[31:0];
   endfunction

endpackage

/* rtl/core/http_response_framer.sv */
// Top level of the HTTP response framer: stream channels, register and result stage.
//
// The block frames one HTTP/1.1 reply fed as a byte stream. Each transaction on the
// req_ channel carries one reply byte, or, with req_tuser set, a request to clear the
// parser for a new reply. Each accepted transaction yields exactly one transaction
// on the rsp_ channel carrying the event code, any body byte, the parsed status and
// version, and the body, chunked and done flags.
//
// The byte is parsed in the accepting cycle and its result is held in the output
// register. Throughput is one byte per cycle while the receiver keeps up, set by the single
// pass of the parser logic between the parser state and the result register.
// The input is taken whenever the result register is empty or is being drained in
// the same cycle, so a stalled receiver holds rsp_ steady and back-pressures req_.
//
// The csr_ channel writes the head_request bit and is always ready; write it only
// while no reply byte is in flight. Reset is synchronous and active high; it clears
// the parser to the status line phase, empties the result register and clears
// head_request.
module http_response_framer
   import hrf_pkg::*;
#(
   parameter int unsigned LINE_MAX = LINE_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // reply_byte
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_code[2:0], body_byte[10:3], status_code[26:11], version_major[42:27],
   // version_minor[58:43], body_expected[59], chunked_mode[60], reply_done[61], zeros
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // head_request
);
   logic       head_ff;
   logic       vld_ff;
   result_type res_ff, res_new;
   logic       step;

   assign req_tready = !vld_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   hrf_engine #(.LINE_MAX(LINE_MAX)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .clear        (req_tuser),
      .byte_in      (req_tdata),
      .head_request (head_ff),
      .result       (res_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         if (csr_valid) head_ff <= csr_data;
         if (step) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
      if (step) res_ff <= res_new;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {2'b00, res_ff.reply_done, res_ff.chunked_mode, res_ff.body_expected,
                        res_ff.version_minor, res_ff.version_major, res_ff.status_code,
                        res_ff.body_byte, res_ff.event_code};

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result register full");
   a_body_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res_ff.event_code != EV_BODY |-> res_ff.body_byte == 8'd0)
      else $error("body byte set outside a body event");
`endif
endmodule

/* rtl/core/hrf_engine.sv */
// Parser state and the single-pass next-state logic for one reply byte.
module hrf_engine
   import hrf_pkg::*;
#(
   parameter int unsigned LINE_MAX = LINE_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       clear,
   input  logic [7:0] byte_in,
   input  logic       head_request,
   output result_type result
);
   localparam int LW = $clog2(LINE_MAX);
   localparam logic [LW-1:0] LIMIT = LW'(LINE_MAX - 1);

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [LW-1:0] len_ff, len_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in, rem_ff, rem_in;
   logic        unl_ff, unl_in, cr_ff, cr_in;
   logic [15:0] maj_ff, maj_in, min_ff, min_in, code_ff, code_in;
   logic        fch_ff, fch_in, fbd_ff, fbd_in;

   logic [2:0] ev;
   logic [7:0] bout;

   // Feed one character to the line matcher; works on the *_in variables.
   function automatic void feed(input logic [7:0] b, input phase_type ph,
                                inout kind_type k, inout logic [4:0] p,
                                inout logic [31:0] a, inout logic [15:0] mj,
                                inout logic [15:0] mn, inout logic [15:0] cd);
      logic [7:0] c;
      logic [4:0] h;
      logic       fall;
      c = to_lower(b);
      h = hex_val(b);
      fall = 1'b0;
      if (ph == PH_STATUS) begin
         case (k)
            K_S_PFX: begin
               if (p < 5'd5 && b == http_char(p)) begin
                  p = p + 5'd1;
                  if (p == 5'd5) begin
                     k = K_S_MAJ_WS; mj = '0; mn = '0; cd = '0;
                  end
               end else k = K_S_FAIL;
            end
            K_S_MAJ_WS:
               if (is_dig(b)) begin k = K_S_MAJ_DIG; mj = {12'd0, b[3:0]}; end
               else if (!is_ws(b)) k = K_S_FAIL;
            K_S_MAJ_DIG:
               if (is_dig(b)) mj = sat16_mac(mj, b[3:0]);
               else k = (b == 8'h2E) ? K_S_MIN_WS : K_S_FAIL;
            K_S_MIN_WS:
               if (is_dig(b)) begin k = K_S_MIN_DIG; mn = {12'd0, b[3:0]}; end
               else if (!is_ws(b)) k = K_S_FAIL;
            K_S_MIN_DIG:
               if (is_dig(b)) mn = sat16_mac(mn, b[3:0]);
               else k = is_ws(b) ? K_S_ST_WS : K_S_FAIL;
            K_S_ST_WS:
               if (is_dig(b)) begin k = K_S_ST_DIG; cd = {12'd0, b[3:0]}; end
               else if (!is_ws(b)) k = K_S_FAIL;
            K_S_ST_DIG:
               if (is_dig(b)) cd = sat16_mac(cd, b[3:0]);
               else k = K_S_OK;
            default: ;
         endcase
      end else if (ph == PH_HEADER || ph == PH_CONTINUE) begin
         case (k)
            K_H_START:
               if (c == 8'h63) begin k = K_H_CL_PFX; p = 5'd1; end
               else if (c == 8'h74) begin k = K_H_TE_PFX; p = 5'd1; end
               else k = K_H_NONE;
            K_H_CL_PFX:
               if (p < 5'd15 && c == cl_char(p)) begin
                  p = p + 5'd1;
                  if (p == 5'd15) begin k = K_H_CL_WS; p = '0; end
               end else k = K_H_NONE;
            K_H_TE_PFX:
               if (p < 5'd18 && c == te_char(p)) begin
                  p = p + 5'd1;
                  if (p == 5'd18) begin k = K_H_TE_WS; p = '0; end
               end else k = K_H_NONE;
            K_H_CL_WS: begin
               if (is_ws(b)) ;
               else if (b == 8'h2B || b == 8'h2D) begin
                  k = K_H_CL_SIGN; p = {4'd0, b == 8'h2D};
               end else fall = 1'b1;
            end
            K_H_CL_SIGN, K_H_CL_DIG: fall = 1'b1;
            K_H_TE_WS:
               if (is_ws(b)) ;
               else if (c == 8'h63) begin k = K_H_TE_VAL; p = 5'd1; end
               else k = K_H_NONE;
            K_H_TE_VAL:
               if (p < 5'd7) begin
                  if (c == ch_char(p)) p = p + 5'd1;
                  else k = K_H_NONE;
               end else k = (b == 8'h00) ? K_H_TE_OK : K_H_NONE;
            default: ;
         endcase
         if (fall) begin
            if (is_dig(b)) begin k = K_H_CL_DIG; a = acc_mac(a, 1'b0, b[3:0]); end
            else k = K_H_CL_END;
         end
      end else if (ph == PH_CHUNKED) begin
         case (k)
            K_X_WS: begin
               if (is_ws(b)) ;
               else if (b == 8'h2B || b == 8'h2D) begin
                  k = K_X_SIGN; p = {4'd0, b == 8'h2D};
               end else fall = 1'b1;
            end
            K_X_SIGN: fall = 1'b1;
            K_X_ZERO:
               if (b == 8'h78 || b == 8'h58) k = K_X_X;
               else if (h[4]) begin k = K_X_DIG; a = acc_mac(a, 1'b1, h[3:0]); end
               else k = K_X_END;
            K_X_X, K_X_DIG:
               if (h[4]) begin k = K_X_DIG; a = acc_mac(a, 1'b1, h[3:0]); end
               else k = K_X_END;
            default: ;
         endcase
         if (fall) begin
            if (b == 8'h30) k = K_X_ZERO;
            else if (h[4]) begin k = K_X_DIG; a = acc_mac(a, 1'b1, h[3:0]); end
            else k = K_X_BAD;
         end
      end
   endfunction

   function automatic kind_type line_kind(input phase_type ph);
      case (ph)
         PH_STATUS: return K_S_PFX;
         PH_HEADER, PH_CONTINUE: return K_H_START;
         PH_CHUNKED: return K_X_WS;
         default: return K_IDLE;
      endcase
   endfunction

   always_comb begin
      logic       do_end, empty, none, ok;
      logic [31:0] sval;
      phase_in = phase_ff; kind_in = kind_ff; len_in = len_ff; pos_in = pos_ff;
      acc_in = acc_ff; rem_in = rem_ff; unl_in = unl_ff; cr_in = cr_ff;
      maj_in = maj_ff; min_in = min_ff; code_in = code_ff;
      fch_in = fch_ff; fbd_in = fbd_ff;
      ev = EV_NONE; bout = '0;
      do_end = 1'b0; empty = 1'b0; none = 1'b0; ok = 1'b0; sval = '0;
      if (clear) begin
         phase_in = PH_STATUS; len_in = '0; cr_in = 1'b0; rem_in = '0; unl_in = 1'b1;
         fch_in = 1'b0; fbd_in = 1'b0; maj_in = 16'd1; min_in = '0; code_in = '0;
         pos_in = '0; acc_in = '0; kind_in = K_S_PFX;
      end else if (phase_ff == PH_DONE) begin
         ev = EV_IGNORED;
      end else if (phase_ff == PH_DATA) begin
         if (unl_ff) begin ev = EV_BODY; bout = byte_in; end
         else if (rem_ff == '0) begin phase_in = PH_DONE; ev = EV_IGNORED; end
         else begin
            ev = EV_BODY; bout = byte_in; rem_in = rem_ff - 32'd1;
            if (rem_ff == 32'd1) phase_in = PH_DONE;
         end
      end else if (phase_ff == PH_CHUNKED && rem_ff != '0) begin
         ev = EV_BODY; bout = byte_in; rem_in = rem_ff - 32'd1;
      end else begin
         if (byte_in == 8'h0A) begin
            do_end = 1'b1;
            empty = (len_ff == (cr_ff ? LW'(1) : LW'(0)));
         end else begin
            if (cr_ff) begin
               feed(8'h0D, phase_ff, kind_in, pos_in, acc_in, maj_in, min_in, code_in);
               cr_in = 1'b0;
            end
            len_in = len_ff + LW'(1);
            if (len_in >= LIMIT) begin
               feed(byte_in, phase_ff, kind_in, pos_in, acc_in, maj_in, min_in, code_in);
               do_end = 1'b1;
            end else if (byte_in == 8'h0D) cr_in = 1'b1;
            else feed(byte_in, phase_ff, kind_in, pos_in, acc_in, maj_in, min_in, code_in);
         end
         if (do_end) begin
            len_in = '0; cr_in = 1'b0;
            sval = (pos_in[0] && acc_in != '0) ? SAT32 : acc_in;
            case (phase_ff)
               PH_STATUS: begin
                  ok = (kind_in == K_S_OK || kind_in == K_S_ST_DIG);
                  if (!ok) begin maj_in = 16'd1; min_in = '0; code_in = 16'd599; end
                  fch_in = 1'b0; fbd_in = 1'b0; unl_in = 1'b1; rem_in = '0;
                  ev = EV_STATUS;
                  if (code_in == 16'd100) phase_in = PH_CONTINUE;
                  else begin
                     none = (code_in >= 16'd100 && code_in <= 16'd199) ||
                            code_in == 16'd204 || code_in == 16'd205 || code_in == 16'd304;
                     fbd_in = !head_request && !none;
                     phase_in = PH_HEADER;
                  end
               end
               PH_HEADER, PH_CONTINUE: begin
                  if (!empty) begin
                     ev = EV_HEADER;
                     if (kind_in == K_H_CL_WS || kind_in == K_H_CL_SIGN ||
                         kind_in == K_H_CL_DIG || kind_in == K_H_CL_END) begin
                        rem_in = sval; unl_in = 1'b0;
                        if (sval == '0) fbd_in = 1'b0;
                     end else if (kind_in == K_H_TE_OK ||
                                  (kind_in == K_H_TE_VAL && pos_in == 5'd7)) begin
                        fch_in = 1'b1;
                     end
                  end else if (fbd_ff) begin
                     if (fch_ff) begin
                        phase_in = PH_CHUNKED; rem_in = '0; unl_in = 1'b0;
                     end else if (!unl_ff && rem_ff == '0) begin
                        phase_in = PH_DONE; ev = EV_DONE;
                     end else phase_in = PH_DATA;
                  end else if (phase_ff == PH_CONTINUE) phase_in = PH_STATUS;
                  else begin phase_in = PH_DONE; ev = EV_DONE; end
               end
               PH_CHUNKED: begin
                  if (!empty) begin
                     if (kind_in == K_X_WS || kind_in == K_X_SIGN || kind_in == K_X_BAD)
                        ev = EV_BADCHNK;
                     else begin
                        rem_in = sval;
                        if (sval == '0) phase_in = PH_FOOTER;
                     end
                  end
               end
               PH_FOOTER: begin
                  if (empty) begin phase_in = PH_DONE; ev = EV_DONE; end
                  else ev = EV_FOOTER;
               end
               default: ;
            endcase
            pos_in = '0; acc_in = '0;
            kind_in = line_kind(phase_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; kind_ff <= K_S_PFX; len_ff <= '0; pos_ff <= '0;
         acc_ff <= '0; rem_ff <= '0; unl_ff <= 1'b1; cr_ff <= 1'b0;
         maj_ff <= 16'd1; min_ff <= '0; code_ff <= '0; fch_ff <= 1'b0; fbd_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; kind_ff <= kind_in; len_ff <= len_in; pos_ff <= pos_in;
         acc_ff <= acc_in; rem_ff <= rem_in; unl_ff <= unl_in; cr_ff <= cr_in;
         maj_ff <= maj_in; min_ff <= min_in; code_ff <= code_in;
         fch_ff <= fch_in; fbd_ff <= fbd_in;
      end
   end

   always_comb begin
      result.event_code    = ev;
      result.body_byte     = bout;
      result.status_code   = code_in;
      result.version_major = maj_in;
      result.version_minor = min_in;
      result.body_expected = fbd_in;
      result.chunked_mode  = fch_in;
      result.reply_done    = (phase_in == PH_DONE);
   end

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff < LIMIT) else $error("line length passed its limit");
   a_done_ignored: assert property (@(posedge clock) disable iff (reset)
      step && !clear && phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("done phase left without a clear");
   a_clear_status: assert property (@(posedge clock) disable iff (reset)
      step && clear |=> phase_ff == PH_STATUS && rem_ff == '0)
      else $error("clear did not restore the status phase");
`endif
endmodule
